/* hdl/bmhq_pkg.sv */
package bmhq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ENTRY_W  = 7;
  localparam int unsigned WIDE_W   = IDX_W + 2;

  typedef logic signed [31:0] key_t;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POP    = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic        command;
    key_t        priority_req;
    logic [31:0] payload;
  } in_t;

  typedef struct packed {
    key_t               top_key;
    logic [31:0]        top_payload;
    logic               top_valid;
    logic [ENTRY_W-1:0] entry_count;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    key_t        key;
    logic [31:0] tag;
  } entry_t;

  // datapath operations issued by the controller
  typedef enum logic [2:0] {
    OP_IDLE      = 3'd0,
    OP_ACCEPT    = 3'd1,
    OP_LOAD_LAST = 3'd2,
    OP_UP_STEP   = 3'd3,
    OP_UP_CMP    = 3'd4,
    OP_DN_STEP   = 3'd5,
    OP_DN_CMP    = 3'd6,
    OP_FINISH    = 3'd7
  } op_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic leaf;
    logic up_move;
    logic dn_move;
  } dp_stat_t;

endpackage

/* hdl/binary_min_heap_queue.sv */
// Channel | Dir | Handshake                  | Payload
// in      | in  | in_valid_i / in_ready_o    | in_i  (command, priority_req, payload)
// out     | out | out_valid_o / out_ready_i  | out_o (top entry, valid, count, status)
//
// One item at a time: after the accept, an insert repeats a climb step and a
// compare per level until it reaches the root or a compare stops it; a pop
// loads the last entry, then repeats a descend step and a compare per level
// until it stops at a leaf or on a compare. The worst case at 64 entries is an
// insert climbing six levels, set by the sift loop's read-compare-write on the
// entry memory. Dropped inserts and empty-heap pops go straight to the finish.
// Reset clears the entry count and the sequencer; the memory needs no clearing pass.
// A stalled result holds the finishing step; the next item is taken once the
// result has moved into the output register.
module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: accept, sift up or sift down, then hand off the result
  bmhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_command_i(in_i.command),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // entry memory, moving-entry register, root mirror and result register
  bmhq_datapath u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd),
    .in_i  (in_i),
    .stat_o(stat),
    .out_o (out_o)
  );

endmodule

/* hdl/bmhq_ctrl.sv */
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     in_command_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_UP   = 7'b0000100,
    S_UPC  = 7'b0001000,
    S_DN   = 7'b0010000,
    S_DNC  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o.op    = OP_IDLE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          if (in_command_i == CMD_INSERT) begin
            state_d = stat_i.full ? S_FIN : S_UP;
          end else begin
            state_d = stat_i.empty ? S_FIN : S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd_o.op = OP_LOAD_LAST;
        state_d  = S_DN;
      end
      S_UP: begin
        cmd_o.op = OP_UP_STEP;
        state_d  = stat_i.pos_zero ? S_FIN : S_UPC;
      end
      S_UPC: begin
        cmd_o.op = OP_UP_CMP;
        state_d  = stat_i.up_move ? S_UP : S_FIN;
      end
      S_DN: begin
        cmd_o.op = OP_DN_STEP;
        state_d  = stat_i.leaf ? S_FIN : S_DNC;
      end
      S_DNC: begin
        cmd_o.op = OP_DN_CMP;
        state_d  = stat_i.dn_move ? S_DN : S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd_o.op    = OP_FINISH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* hdl/bmhq_datapath.sv */
module bmhq_datapath
  import bmhq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  dp_cmd_t  cmd_i,
  input  in_t      in_i,
  output dp_stat_t stat_o,
  output out_t     out_o
);

  entry_t mem_q [CAPACITY];
  entry_t rd_a_q, rd_b_q;
  entry_t cur_q, root_q, pick;
  logic [IDX_W-1:0]  pos_q, parent, pick_idx, rd_addr_a, rd_addr_b, waddr;
  logic [CNT_W-1:0]  count_q;
  logic [1:0]        status_q;
  logic [WIDE_W-1:0] left, right, count_w;
  logic              take_right, we;
  entry_t            wdata;
  out_t              out_q;

  assign parent     = IDX_W'((pos_q - 1'b1) >> 1);
  assign left       = {1'b0, pos_q, 1'b1};
  assign right      = left + 1'b1;
  assign count_w    = WIDE_W'(count_q);
  assign take_right = (right < count_w) && (rd_b_q.key < rd_a_q.key);
  assign pick       = take_right ? rd_b_q : rd_a_q;
  assign pick_idx   = take_right ? right[IDX_W-1:0] : left[IDX_W-1:0];

  assign stat_o.full     = (count_q == CNT_W'(CAPACITY));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.pos_zero = (pos_q == '0);
  assign stat_o.leaf     = (left >= count_w);
  assign stat_o.up_move  = (cur_q.key < rd_a_q.key);
  assign stat_o.dn_move  = (pick.key < cur_q.key);

  // read ports: last entry on a pop, parent going up, children going down
  always_comb begin
    case (cmd_i.op)
      OP_ACCEPT:  rd_addr_a = IDX_W'(count_q - 1'b1);
      OP_UP_STEP: rd_addr_a = parent;
      default:    rd_addr_a = left[IDX_W-1:0];
    endcase
    rd_addr_b = right[IDX_W-1:0];
  end

  // the moving entry stays in cur_q; the hole is filled as it passes
  always_comb begin
    we    = 1'b0;
    waddr = pos_q;
    wdata = cur_q;
    case (cmd_i.op)
      OP_UP_STEP: we = stat_o.pos_zero;
      OP_UP_CMP: begin
        we = 1'b1;
        if (stat_o.up_move) wdata = rd_a_q;
      end
      OP_DN_STEP: we = stat_o.leaf;
      OP_DN_CMP: begin
        we = 1'b1;
        if (stat_o.dn_move) wdata = pick;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_a_q <= mem_q[rd_addr_a];
    rd_b_q <= mem_q[rd_addr_b];
  end

  // entry and output registers carry no reset
  always_ff @(posedge clk_i) begin
    if (we && waddr == '0) root_q <= wdata;
    case (cmd_i.op)
      OP_ACCEPT: begin
        cur_q.key <= in_i.priority_req;
        cur_q.tag <= in_i.payload;
        pos_q     <= count_q[IDX_W-1:0];
      end
      OP_LOAD_LAST: begin
        cur_q <= rd_a_q;
        pos_q <= '0;
      end
      OP_UP_CMP: if (stat_o.up_move) pos_q <= parent;
      OP_DN_CMP: if (stat_o.dn_move) pos_q <= pick_idx;
      OP_FINISH: begin
        out_q.top_key     <= stat_o.empty ? '0 : root_q.key;
        out_q.top_payload <= stat_o.empty ? '0 : root_q.tag;
        out_q.top_valid   <= !stat_o.empty;
        out_q.entry_count <= ENTRY_W'(count_q);
        out_q.status      <= status_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      status_q <= ST_OK;
    end else if (cmd_i.op == OP_ACCEPT) begin
      status_q <= ST_OK;
      if (in_i.command == CMD_INSERT) begin
        if (stat_o.full) status_q <= ST_FULL;
        else count_q <= count_q + 1'b1;
      end else begin
        if (stat_o.empty) status_q <= ST_EMPTY;
        else count_q <= count_q - 1'b1;
      end
    end
  end

  assign out_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_pop_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_ACCEPT && in_i.command == CMD_POP && !stat_o.empty)
    |=> count_q == $past(count_q) - 1'b1)
    else $error("pop did not shrink the heap");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_ACCEPT && in_i.command == CMD_INSERT && stat_o.full)
    |=> (status_q == ST_FULL && $stable(count_q)))
    else $error("insert on full heap not dropped");

  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && !stat_o.empty) |-> (CNT_W'(waddr) < count_q))
    else $error("write beyond stored entries");

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bmhq_pkg::*;

  // Run shape
  localparam int RANDOM_ITEMS = 1700;
  localparam int CALM_TAIL    = 300;   // last items run with no idling on either side
  localparam int STALL_LIMIT  = 2000;  // cycles with no handshake at all before giving up
  localparam int DRAIN_CYCLES = 40;    // settling time after the last result

  localparam key_t KEY_MAX = 32'sh7FFF_FFFF;
  localparam key_t KEY_MIN = 32'sh8000_0000;

  // DUT ports; every input is known from time zero
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_i        = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_o;

  binary_min_heap_queue DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Shadow heap: same array layout and the same sift rules as the block, so the
  // root after every item is known exactly, ties included.
  // ---------------------------------------------------------------------------
  key_t        heap_key [CAPACITY];
  logic [31:0] heap_tag [CAPACITY];
  int          heap_fill = 0;

  // Root snapshots owed by the block, oldest first
  out_t queued_tops [$];

  // Bookkeeping for the summary
  int errors        = 0;
  int results_seen  = 0;
  int n_insert      = 0;
  int n_pop         = 0;
  int n_full_drop   = 0;
  int n_empty_pop   = 0;
  int peak_fill     = 0;
  int idle_cycles   = 0;

  // Idling knobs, set by the stimulus process per phase (percent)
  int gap_pct = 0;
  int rx_pct  = 0;

  function automatic void swap_slots(int a, int b);
    key_t        k;
    logic [31:0] t;
    k           = heap_key[a];
    t           = heap_tag[a];
    heap_key[a] = heap_key[b];
    heap_tag[a] = heap_tag[b];
    heap_key[b] = k;
    heap_tag[b] = t;
  endfunction

  // Applies one item to the shadow heap and returns the root snapshot after it
  function automatic out_t heap_op_result(in_t item);
    out_t    top;
    int      pos;
    int      pick;
    status_e st;
    st  = ST_OK;
    pos = 0;
    if (item.command == CMD_INSERT) begin
      if (heap_fill >= CAPACITY) begin
        st = ST_FULL;                          // dropped, heap untouched
      end else begin
        heap_key[heap_fill] = item.priority_req;
        heap_tag[heap_fill] = item.payload;
        pos                 = heap_fill;
        heap_fill++;
        // climb only while strictly smaller than the parent
        while (pos > 0 && heap_key[pos] < heap_key[(pos - 1) / 2]) begin
          swap_slots(pos, (pos - 1) / 2);
          pos = (pos - 1) / 2;
        end
      end
    end else if (heap_fill == 0) begin
      st = ST_EMPTY;
    end else begin
      heap_fill--;
      heap_key[0] = heap_key[heap_fill];
      heap_tag[0] = heap_tag[heap_fill];
      // descend: right child only when strictly smaller than left,
      // stop once the entry is <= the chosen child
      while (2 * pos + 1 < heap_fill) begin
        pick = 2 * pos + 1;
        if (pick + 1 < heap_fill && heap_key[pick + 1] < heap_key[pick]) pick++;
        if (!(heap_key[pick] < heap_key[pos])) break;
        swap_slots(pos, pick);
        pos = pick;
      end
    end
    top = '0;
    if (heap_fill > 0) begin
      top.top_key     = heap_key[0];
      top.top_payload = heap_tag[0];
      top.top_valid   = 1'b1;
    end
    top.entry_count = ENTRY_W'(heap_fill);
    top.status      = st;
    return top;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed rows. A row either carries its expected root typed in (empty heap,
  // extremes, error codes) or leaves it to the shadow heap.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_t  item;
    bit   fixed;
    out_t want;
  } dir_row_t;

  dir_row_t directed_rows [$];

  function automatic void add_row(cmd_e cmd, key_t key, logic [31:0] tag, bit fixed,
                                  key_t wkey, logic [31:0] wtag, int wcount,
                                  status_e wst);
    dir_row_t r;
    r.item.command      = cmd;
    r.item.priority_req = key;
    r.item.payload      = tag;
    r.fixed             = fixed;
    r.want.top_key      = wkey;
    r.want.top_payload  = wtag;
    r.want.top_valid    = (wcount != 0);
    r.want.entry_count  = ENTRY_W'(wcount);
    r.want.status       = wst;
    directed_rows.push_back(r);
  endfunction

  // Holds valid until accepted, then records what the root must look like.
  // Must be called right after posedge clk_i.
  task automatic push_item(in_t item, bit fixed, out_t want);
    out_t predicted;
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = heap_op_result(item);
    if (item.command == CMD_INSERT) n_insert++;
    else n_pop++;
    if (predicted.status == ST_FULL) n_full_drop++;
    if (predicted.status == ST_EMPTY) n_empty_pop++;
    if (heap_fill > peak_fill) peak_fill = heap_fill;
    queued_tops.push_back(fixed ? want : predicted);
  endtask

  // Random sender idle burst after an accepted item
  task automatic sender_gap();
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Hold the sender off until every owed result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (queued_tops.size() != 0);
  endtask

  task automatic flag_field(string fname, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and watchdog. Sampled at the edge, so values are the ones
  // the handshake actually saw.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (queued_tops.size() == 0) begin
        $display("%0t: result with nothing owed, actual %p", $time, out_o);
        errors++;
      end else begin
        want = queued_tops.pop_front();
        if (out_o.top_key !== want.top_key)
          flag_field("top_key", want.top_key, out_o.top_key);
        if (out_o.top_payload !== want.top_payload)
          flag_field("top_payload", want.top_payload, out_o.top_payload);
        if (out_o.top_valid !== want.top_valid)
          flag_field("top_valid", 32'(want.top_valid), 32'(out_o.top_valid));
        if (out_o.entry_count !== want.entry_count)
          flag_field("entry_count", 32'(want.entry_count), 32'(out_o.entry_count));
        if (out_o.status !== want.status)
          flag_field("status", 32'(want.status), 32'(out_o.status));
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results still owed",
               $time, STALL_LIMIT, queued_tops.size());
      $display("binary_min_heap_queue test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready high stretches, with random stall bursts at rx_pct
  // ---------------------------------------------------------------------------
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_t  item;
    out_t none;
    int   sent;
    int   run_len;
    int   ins_pct;
    bit   tail;

    none = '0;
    sent = 0;

    // Directed: empty-heap pops, extreme keys and payloads, root replacement by
    // a smaller key, equal keys that must not climb, then a full drain.
    add_row(CMD_POP,    '0,      '0,           1, '0,      '0,           0, ST_EMPTY);
    add_row(CMD_INSERT, KEY_MAX, 32'hFFFF_FFFF, 1, KEY_MAX, 32'hFFFF_FFFF, 1, ST_OK);
    add_row(CMD_POP,    '0,      '0,           1, '0,      '0,           0, ST_OK);
    // key and payload of a pop are don't-care
    add_row(CMD_POP,    -32'sd1, 32'hFFFF_FFFF, 1, '0,      '0,           0, ST_EMPTY);
    add_row(CMD_INSERT, KEY_MAX, 32'h0000_0001, 1, KEY_MAX, 32'h0000_0001, 1, ST_OK);
    add_row(CMD_INSERT, KEY_MIN, 32'h0000_0000, 1, KEY_MIN, 32'h0000_0000, 2, ST_OK);
    add_row(CMD_INSERT, -32'sd1, 32'hAAAA_5555, 1, KEY_MIN, 32'h0000_0000, 3, ST_OK);
    add_row(CMD_INSERT, 32'sd0,  32'h5555_AAAA, 0, '0, '0, 0, ST_OK);
    // equal to the root: stays put, root tag unchanged
    add_row(CMD_INSERT, KEY_MIN, 32'h1234_5678, 0, '0, '0, 0, ST_OK);
    add_row(CMD_INSERT, 32'sd1,  32'h0F0F_0F0F, 0, '0, '0, 0, ST_OK);
    add_row(CMD_INSERT, -32'sd1, 32'hF0F0_F0F0, 0, '0, '0, 0, ST_OK);
    add_row(CMD_INSERT, 32'sd7,  32'h0000_0007, 0, '0, '0, 0, ST_OK);
    add_row(CMD_INSERT, 32'sd7,  32'h0000_0070, 0, '0, '0, 0, ST_OK);
    repeat (9) add_row(CMD_POP, '0, '0, 0, '0, '0, 0, ST_OK);
    add_row(CMD_POP,    '0,      '0,           1, '0,      '0,           0, ST_EMPTY);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 20;
    rx_pct  = 30;
    foreach (directed_rows[i]) begin
      push_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].want);
      sender_gap();
    end

    // let everything settle once before going random
    wait_drained();

    // Random: phases biased toward filling (to hit the full drop), draining
    // (to hit empty pops) or churn in the middle. Keys mix full range, a tiny
    // range full of ties, the extremes, and a moderate range.
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       ins_pct = 90;
        1:       ins_pct = 10;
        2:       ins_pct = 50;
        default: ins_pct = 70;
      endcase
      run_len = $urandom_range(20, 120);
      tail    = (sent >= RANDOM_ITEMS - CALM_TAIL);
      gap_pct = tail ? 0 : 15 * $urandom_range(0, 2);
      rx_pct  = tail ? 0 : 25 * $urandom_range(0, 2);
      if (!tail && $urandom_range(0, 7) == 0) wait_drained();

      for (int k = 0; k < run_len; k++) begin
        item.command = ($urandom_range(0, 99) < ins_pct) ? CMD_INSERT : CMD_POP;
        case ($urandom_range(0, 3))
          0: item.priority_req = key_t'($urandom);
          1: item.priority_req = key_t'(int'($urandom_range(0, 8)) - 4);
          2: begin
            case ($urandom_range(0, 4))
              0:       item.priority_req = KEY_MIN;
              1:       item.priority_req = KEY_MAX;
              2:       item.priority_req = -32'sd1;
              3:       item.priority_req = 32'sd0;
              default: item.priority_req = 32'sd1;
            endcase
          end
          default: item.priority_req = key_t'(int'($urandom_range(0, 2000)) - 1000);
        endcase
        item.payload = $urandom;
        push_item(item, 1'b0, none);
        sent++;
        sender_gap();
      end
    end
    in_valid_i <= 1'b0;

    // wait out every owed result, then a little longer for stray outputs
    do @(posedge clk_i); while (queued_tops.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d inserts (%0d dropped at full) and %0d pops (%0d on empty),",
             n_insert, n_full_drop, n_pop, n_empty_pop);
    $display("peak fill %0d of %0d, %0d results checked, %0d mismatches.",
             peak_fill, CAPACITY, results_seen, errors);
    if (errors == 0) begin
      $display("binary_min_heap_queue test passed");
    end else begin
      $display("binary_min_heap_queue test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bmhq_pkg.sv
hdl/bmhq_ctrl.sv
hdl/bmhq_datapath.sv
hdl/binary_min_heap_queue.sv
dv/tb_top.sv
